/* hw/rtl/delimited_frame_field_splitter_assert.svh */
// Assertion macros shared by the frame field splitter RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef DELIMITED_FRAME_FIELD_SPLITTER_ASSERT_SVH
`define DELIMITED_FRAME_FIELD_SPLITTER_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define DFFS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define DFFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/dffs_pkg.sv */
// Shared constants, types and helper widths for the frame field splitter.
// No dependencies; dffs_core, dffs_skid and the top module import this package.
`default_nettype none

package dffs_pkg;

    // Frame limits
    localparam int MAX_FIELDS  = 8;
    localparam int FIELD_CHARS = 4;
    localparam int PAYLOAD_MAX = 32;

    // Characters kept in the reported text
    localparam int TEXT_BYTES = 4;

    localparam int FDONE_W  = $clog2(MAX_FIELDS + 1);
    localparam int PLEN_W   = $clog2(FIELD_CHARS + 1);
    localparam int PCOUNT_W = $clog2(PAYLOAD_MAX + 1);

    typedef logic [7:0] char_t;

    // Marker, separator and filler characters
    localparam char_t CH_F     = 8'h46;
    localparam char_t CH_R     = 8'h52;
    localparam char_t CH_COLON = 8'h3A;
    localparam char_t CH_SLASH = 8'h2F;
    localparam char_t CH_FILL  = 8'h3F;
    localparam char_t CH_ZERO  = 8'h30;
    localparam char_t DEC_BASE = 8'd10;

    // One result item
    typedef struct packed {
        logic [2:0]  field_index;
        logic [31:0] field_text;
        logic [2:0]  field_length;
        logic [7:0]  field_number;
        logic        field_valid;
        logic        last;
        logic        overflow;
    } result_t;

endpackage

`default_nettype wire

/* hw/rtl/dffs_in_if.sv */
// Input channel: one received byte per item, valid/ready handshake.
// Depends on nothing.
`default_nettype none

interface dffs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* hw/rtl/dffs_out_if.sv */
// Output channel: one field result per item, valid/ready handshake.
// Depends on nothing.
`default_nettype none

interface dffs_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  field_index;
    logic [31:0] field_text;
    logic [2:0]  field_length;
    logic [7:0]  field_number;
    logic        field_valid;
    logic        last;
    logic        overflow;

    modport source (
        output valid, output field_index, output field_text, output field_length,
        output field_number, output field_valid, output last, output overflow,
        input ready
    );
    modport sink (
        input valid, input field_index, input field_text, input field_length,
        input field_number, input field_valid, input last, input overflow,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/dffs_core.sv */
// Frame state: marker window, payload release, field accumulation.
// Depends on dffs_pkg and the assertion macro header.
`default_nettype none

`include "delimited_frame_field_splitter_assert.svh"

module dffs_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire dffs_pkg::char_t rx_byte,
    output logic                 res_valid,
    output dffs_pkg::result_t    res
);
    import dffs_pkg::*;

    char_t                win0_reg, win1_reg, win2_reg;
    char_t                win0_next, win1_next, win2_next;
    logic [1:0]           piw_reg, piw_next;
    logic                 in_frame_reg, in_frame_next;
    logic [31:0]          pchars_reg, pchars_next, pchars1;
    logic [PLEN_W-1:0]    plen_reg, plen_next, plen1;
    logic [7:0]           pval_reg, pval_next, pval1;
    logic [FDONE_W-1:0]   fdone_reg, fdone_next, fdone1;
    logic [PCOUNT_W-1:0]  pcount_reg, pcount_next, pcount1;
    logic                 ovf_reg, ovf_next, ovf1;
    logic                 have_rel;
    logic                 start_hit;
    logic                 stop_hit;

    function automatic result_t make_result(
        input logic               fv,
        input logic [FDONE_W-1:0] idx,
        input logic [31:0]        chars,
        input logic [PLEN_W-1:0]  len,
        input logic [7:0]         val,
        input logic               ovf,
        input logic               lst
    );
        result_t r;
        r = '0;
        if (fv)
        begin
            r.field_index  = 3'(idx);
            r.field_text   = chars;
            r.field_length = (int'(len) < TEXT_BYTES) ? 3'(len) : 3'(TEXT_BYTES);
            r.field_number = val;
        end
        r.field_valid = fv;
        r.last        = lst;
        r.overflow    = ovf;
        return r;
    endfunction

    // Work out the next state and any result for the byte at the input register
    always_comb
    begin
        win0_next     = win1_reg;
        win1_next     = win2_reg;
        win2_next     = rx_byte;
        piw_next      = piw_reg;
        in_frame_next = in_frame_reg;
        pchars1       = pchars_reg;
        plen1         = plen_reg;
        pval1         = pval_reg;
        fdone1        = fdone_reg;
        pcount1       = pcount_reg;
        ovf1          = ovf_reg;
        res_valid     = 1'b0;
        res           = '0;

        have_rel  = (piw_reg == 2'd3);
        start_hit = !in_frame_reg && win1_reg == CH_F && win2_reg == CH_R
                    && rx_byte == CH_COLON;
        stop_hit  = in_frame_reg && win1_reg == CH_COLON && win2_reg == CH_F
                    && rx_byte == CH_R;

        if (!in_frame_reg)
        begin
            // Hunt for the start marker
            if (start_hit)
            begin
                in_frame_next = 1'b1;
                piw_next      = 2'd0;
            end
        end
        else
        begin
            if (piw_reg != 2'd3)
                piw_next = piw_reg + 2'd1;

            // Handle the byte leaving the window
            if (have_rel)
            begin
                if (pcount_reg >= PCOUNT_W'(PAYLOAD_MAX))
                    ovf1 = 1'b1;
                else
                begin
                    pcount1 = pcount_reg + PCOUNT_W'(1);
                    if (win0_reg == CH_SLASH)
                    begin
                        if (fdone_reg >= FDONE_W'(MAX_FIELDS))
                            ovf1 = 1'b1;
                        else
                        begin
                            res_valid = 1'b1;
                            res = make_result(1'b1, fdone_reg, pchars_reg, plen_reg,
                                              pval_reg, ovf_reg, stop_hit);
                            fdone1 = fdone_reg + FDONE_W'(1);
                        end
                        pchars1 = '0;
                        plen1   = '0;
                        pval1   = '0;
                    end
                    else if (plen_reg >= PLEN_W'(FIELD_CHARS))
                        ovf1 = 1'b1;
                    else
                    begin
                        for (int k = 0; k < TEXT_BYTES; k++)
                        begin
                            if (int'(plen_reg) == k)
                                pchars1[8*k +: 8] = win0_reg;
                        end
                        pval1 = 8'(pval_reg * DEC_BASE + win0_reg - CH_ZERO);
                        plen1 = plen_reg + PLEN_W'(1);
                    end
                end
            end

            // Close the frame on the stop marker
            if (stop_hit)
            begin
                if (!res_valid)
                begin
                    res_valid = 1'b1;
                    if (plen1 != '0 && fdone1 < FDONE_W'(MAX_FIELDS))
                        res = make_result(1'b1, fdone1, pchars1, plen1, pval1, ovf1, 1'b1);
                    else
                        res = make_result(1'b0, fdone1, pchars1, plen1, pval1,
                                          ovf1 | (plen1 != '0), 1'b1);
                end
                win0_next     = CH_FILL;
                win1_next     = CH_FILL;
                win2_next     = CH_FILL;
                piw_next      = 2'd0;
                in_frame_next = 1'b0;
                pchars1       = '0;
                plen1         = '0;
                pval1         = '0;
                fdone1        = '0;
                pcount1       = '0;
                ovf1          = 1'b0;
            end
        end

        pchars_next = pchars1;
        plen_next   = plen1;
        pval_next   = pval1;
        fdone_next  = fdone1;
        pcount_next = pcount1;
        ovf_next    = ovf1;
    end

    // Advance the state on each processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win0_reg     <= CH_FILL;
            win1_reg     <= CH_FILL;
            win2_reg     <= CH_FILL;
            piw_reg      <= 2'd0;
            in_frame_reg <= 1'b0;
            pchars_reg   <= '0;
            plen_reg     <= '0;
            pval_reg     <= '0;
            fdone_reg    <= '0;
            pcount_reg   <= '0;
            ovf_reg      <= 1'b0;
        end
        else if (step)
        begin
            win0_reg     <= win0_next;
            win1_reg     <= win1_next;
            win2_reg     <= win2_next;
            piw_reg      <= piw_next;
            in_frame_reg <= in_frame_next;
            pchars_reg   <= pchars_next;
            plen_reg     <= plen_next;
            pval_reg     <= pval_next;
            fdone_reg    <= fdone_next;
            pcount_reg   <= pcount_next;
            ovf_reg      <= ovf_next;
        end
    end

    `DFFS_ASSERT_NOW(a_res_in_frame, res_valid, in_frame_reg, "result outside a frame")
    `DFFS_ASSERT_NEXT(a_last_ends_frame, step && res_valid && res.last, !in_frame_reg && piw_reg == 2'd0, "frame not closed after last")
    `DFFS_ASSERT_NOW(a_bare_end_empty, res_valid && !res.field_valid, res.last && res.field_text == '0 && res.field_length == '0, "bare end carries field data")

endmodule

`default_nettype wire

/* hw/rtl/dffs_skid.sv */
// Output result register with a skid stage behind it.
// Depends on dffs_pkg, dffs_out_if and the assertion macro header.
`default_nettype none

`include "delimited_frame_field_splitter_assert.svh"

module dffs_skid (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire dffs_pkg::result_t push_res,
    output logic                   full,
    dffs_out_if.source             fields
);
    import dffs_pkg::*;

    logic    out_valid_reg;
    result_t out_res_reg;
    logic    skid_valid_reg;
    result_t skid_res_reg;
    logic    out_free;

    assign out_free = !out_valid_reg || fields.ready;
    assign full     = skid_valid_reg;

    // Track which stages hold an item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
            skid_valid_reg <= 1'b1;
    end

    // Move payloads: skid drains first, else take the new item
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_res_reg <= skid_res_reg;
            else if (push)
                out_res_reg <= push_res;
        end
        else if (push)
            skid_res_reg <= push_res;
    end

    assign fields.valid        = out_valid_reg;
    assign fields.field_index  = out_res_reg.field_index;
    assign fields.field_text   = out_res_reg.field_text;
    assign fields.field_length = out_res_reg.field_length;
    assign fields.field_number = out_res_reg.field_number;
    assign fields.field_valid  = out_res_reg.field_valid;
    assign fields.last         = out_res_reg.last;
    assign fields.overflow     = out_res_reg.overflow;

    `DFFS_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid holds item with output empty")
    `DFFS_ASSERT_NOW(a_no_push_full, push, !skid_valid_reg, "item pushed into a full buffer")
    `DFFS_ASSERT_NEXT(a_out_held, out_valid_reg && !fields.ready, out_valid_reg, "stalled item dropped")

endmodule

`default_nettype wire

/* hw/rtl/delimited_frame_field_splitter.sv */
// Frame field splitter: input register, frame logic, result register with skid.
// An accepted byte waits in the input register until processed; its result is then registered.
// Throughput: one byte per cycle while the result side keeps taking items.
// Reset (rst_n low, asynchronous): window filled with '?', hunting, all counts clear.
// Depends on dffs_pkg, dffs_in_if, dffs_out_if, dffs_core and dffs_skid.
`default_nettype none

module delimited_frame_field_splitter (
    input  wire logic  clk,
    input  wire logic  rst_n,
    dffs_in_if.sink    rx,
    dffs_out_if.source fields
);
    import dffs_pkg::*;

    logic    in_valid_reg;
    char_t   in_byte_reg;
    logic    fire;
    logic    skid_full;
    logic    res_valid;
    result_t res;

    // Process the held byte unless the output side is backed up
    assign fire     = in_valid_reg && !skid_full;
    assign rx.ready = !in_valid_reg || fire;

    // Hold the accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (rx.valid && rx.ready)
            in_valid_reg <= 1'b1;
        else if (fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
            in_byte_reg <= rx.rx_byte;
    end

    dffs_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (fire),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    dffs_skid u_skid (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fire && res_valid),
        .push_res (res),
        .full     (skid_full),
        .fields   (fields)
    );

endmodule

`default_nettype wire
